[src/tpcd_pkg.sv]
// Package: shared types and codes for the trigger pulse and clock divider block.
`timescale 1ns / 1ps

package tpcd_pkg;

  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PIN_W   = 4;
  localparam int unsigned LEVELS_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLK_ONE_DIV   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLK_TWO_DIV   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_CLK_DIV = 2'd3;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_PULSE     = 3'd1;
  localparam logic [2:0] CMD_CLK_TICK  = 3'd2;
  localparam logic [2:0] CMD_RESET_OUT = 3'd3;
  localparam logic [2:0] CMD_EXT_EDGE  = 3'd4;
  localparam logic [2:0] CMD_RESET_IN  = 3'd5;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [PIN_W-1:0] pin_index;
    logic             level;
  } cmd_item_t;

  typedef struct packed {
    logic [LEVELS_W-1:0] pin_levels;
    logic                step_request;
    logic                running;
  } res_item_t;

  typedef enum logic [1:0] {
    PIN_NOP,
    PIN_AGE,
    PIN_FIRE,
    PIN_SET
  } pin_op_code_t;

  typedef struct packed {
    pin_op_code_t     code;
    logic [PIN_W-1:0] idx;
    logic             level;
  } pin_op_t;

  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [7:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } mod_rsp_t;

endpackage

[src/trigger_pulse_and_clock_divider.sv]
// Top level: trigger pulse and clock divider with sequencer and result register.
//
//  channel  direction  handshake             payload
//  cmd      in         cmd_valid/cmd_stall   cmd_item  (cmd, pin_index, level)
//  res      out        res_valid/res_stall   res_item  (pin_levels, step_request, running)
//  cfg      in         cfg_we                cfg_index, cfg_data
//
// Time tick: every pin timer aged in turn, one pin timer per cycle.
// Clock tick: two passes of the serial modulo unit.
// External edge: one modulo pass. Other commands go straight to the result stage.
// One beat in flight at a time; a waiting result holds until res_stall drops.
// rst is synchronous; no clearing pass is needed after it.
`timescale 1ns / 1ps

module trigger_pulse_and_clock_divider #(
  parameter int unsigned PIN_COUNT = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  tpcd_pkg::cmd_item_t                 cmd_item,
  output logic                                res_valid,
  input  logic                                res_stall,
  output tpcd_pkg::res_item_t                 res_item,
  input  logic                                cfg_we,
  input  logic [tpcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpcd_pkg::CFG_W-1:0]          cfg_data
);
  import tpcd_pkg::*;

  localparam int unsigned IDX_W = $clog2(PIN_COUNT);
  localparam logic [IDX_W-1:0] AGE_LAST    = IDX_W'(PIN_COUNT - 1);
  localparam logic [PIN_W-1:0] CLK_ONE_PIN = PIN_W'(PIN_COUNT - 3);
  localparam logic [PIN_W-1:0] CLK_TWO_PIN = PIN_W'(PIN_COUNT - 2);
  localparam logic [PIN_W-1:0] RST_PIN     = PIN_W'(PIN_COUNT - 1);
  localparam logic [PIN_W:0]   PIN_LIMIT   = (PIN_W + 1)'(PIN_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AGE,
    S_MOD_C1,
    S_MOD_C2,
    S_MOD_IN,
    S_FINISH
  } state_t;

  state_t               state;
  logic [CFG_W-1:0]     pulse_ticks;
  logic [7:0]           clock_one_divider;
  logic [7:0]           clock_two_divider;
  logic [7:0]           input_clock_divider;
  logic [7:0]           clock_count;
  logic [7:0]           input_edge_count;
  logic                 run_flag;
  logic                 step;
  logic [IDX_W-1:0]     age_idx;
  logic                 accept;
  pin_op_t              pin_op;
  mod_req_t             mod_req;
  mod_rsp_t             mod_rsp;
  logic [PIN_COUNT-1:0] pin_state;
  logic [PIN_COUNT+LEVELS_W-1:0] levels_wide;

  assign cmd_stall   = (state != S_IDLE);
  assign accept      = cmd_valid && !cmd_stall;
  assign levels_wide = {{LEVELS_W{1'b0}}, pin_state};

  tpcd_pins #(.PIN_COUNT(PIN_COUNT)) u_pins (
    .clk          (clk),
    .rst          (rst),
    .pulse_ticks  (pulse_ticks),
    .op           (pin_op),
    .pin_state    (pin_state)
  );

  tpcd_mod8 u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  always_comb begin
    pin_op  = '{code: PIN_NOP, idx: '0, level: 1'b0};
    mod_req = '{start: 1'b0, dividend: '0, divisor: '0};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_item.cmd)
            CMD_PULSE: begin
              if ({1'b0, cmd_item.pin_index} < PIN_LIMIT) begin
                pin_op = '{code: PIN_FIRE, idx: cmd_item.pin_index, level: 1'b1};
              end
            end
            CMD_CLK_TICK:
              mod_req = '{start: 1'b1, dividend: clock_count, divisor: clock_one_divider};
            CMD_RESET_OUT:
              pin_op = '{code: PIN_SET, idx: RST_PIN, level: cmd_item.level};
            CMD_EXT_EDGE:
              mod_req = '{start: 1'b1, dividend: input_edge_count,
                          divisor: input_clock_divider};
            default: ;
          endcase
        end
      end
      S_AGE: pin_op = '{code: PIN_AGE, idx: PIN_W'(age_idx), level: 1'b0};
      S_MOD_C1: begin
        if (mod_rsp.done) begin
          if (mod_rsp.zero) begin
            pin_op = '{code: PIN_FIRE, idx: CLK_ONE_PIN, level: 1'b1};
          end
          mod_req = '{start: 1'b1, dividend: clock_count, divisor: clock_two_divider};
        end
      end
      S_MOD_C2: begin
        if (mod_rsp.done && mod_rsp.zero) begin
          pin_op = '{code: PIN_FIRE, idx: CLK_TWO_PIN, level: 1'b1};
        end
      end
      S_MOD_IN: ;
      S_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      res_valid           <= 1'b0;
      pulse_ticks         <= CFG_W'(10);
      clock_one_divider   <= 8'd8;
      clock_two_divider   <= 8'd8;
      input_clock_divider <= 8'd1;
      clock_count         <= '0;
      input_edge_count    <= '0;
      run_flag            <= 1'b0;
      step                <= 1'b0;
      age_idx             <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PULSE_TICKS:   pulse_ticks         <= cfg_data;
          REG_CLK_ONE_DIV:   clock_one_divider   <= cfg_data[7:0];
          REG_CLK_TWO_DIV:   clock_two_divider   <= cfg_data[7:0];
          REG_INPUT_CLK_DIV: input_clock_divider <= cfg_data[7:0];
        endcase
      end
      if (res_valid && !res_stall && state != S_FINISH) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            step  <= 1'b0;
            state <= S_FINISH;
            unique case (cmd_item.cmd)
              CMD_TICK: begin
                age_idx <= '0;
                state   <= S_AGE;
              end
              CMD_CLK_TICK: state <= S_MOD_C1;
              CMD_RESET_OUT: begin
                if (cmd_item.level) begin
                  clock_count <= '0;
                end
              end
              CMD_EXT_EDGE: state <= S_MOD_IN;
              CMD_RESET_IN: run_flag <= !cmd_item.level;
              default: ;
            endcase
          end
        end
        S_AGE: begin
          age_idx <= age_idx + IDX_W'(1);
          if (age_idx == AGE_LAST) begin
            state <= S_FINISH;
          end
        end
        S_MOD_C1: begin
          if (mod_rsp.done) begin
            state <= S_MOD_C2;
          end
        end
        S_MOD_C2: begin
          if (mod_rsp.done) begin
            clock_count <= clock_count + 8'd1;
            state       <= S_FINISH;
          end
        end
        S_MOD_IN: begin
          if (mod_rsp.done) begin
            step             <= mod_rsp.zero && run_flag;
            input_edge_count <= input_edge_count + 8'd1;
            state            <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!res_valid || !res_stall) begin
            res_valid             <= 1'b1;
            res_item.pin_levels   <= levels_wide[LEVELS_W-1:0];
            res_item.step_request <= step;
            res_item.running      <= run_flag;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    accept |=> cmd_stall)
    else $error("second beat taken while one is in flight");

  a_mod_done_state: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> (state == S_MOD_C1 || state == S_MOD_C2 || state == S_MOD_IN))
    else $error("modulo result arrived outside a modulo state");

  a_step_running: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.step_request |-> res_item.running)
    else $error("step request while stopped");

endmodule

[src/tpcd_mod8.sv]
// Bit-serial 8-bit modulo unit: reports whether dividend mod divisor is zero.
`timescale 1ns / 1ps

module tpcd_mod8 (
  input  logic               clk,
  input  logic               rst,
  input  tpcd_pkg::mod_req_t req,
  output tpcd_pkg::mod_rsp_t rsp
);
  import tpcd_pkg::*;

  logic       busy;
  logic [2:0] bit_cnt;
  logic [7:0] dvd;
  logic [7:0] div;
  logic [7:0] rem;
  logic [8:0] trial;
  logic [7:0] rem_next;

  always_comb begin
    trial = {rem, dvd[7]};
    if (trial >= {1'b0, div}) begin
      rem_next = 8'(trial - {1'b0, div});
    end else begin
      rem_next = trial[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
      rsp     <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        bit_cnt <= '0;
        dvd     <= req.dividend;
        div     <= (req.divisor == 8'd0) ? 8'd1 : req.divisor;
        rem     <= '0;
      end else if (busy) begin
        rem     <= rem_next;
        dvd     <= {dvd[6:0], 1'b0};
        bit_cnt <= bit_cnt + 3'd1;
        if (bit_cnt == 3'd7) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
          rsp.zero <= (rem_next == 8'd0);
        end
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start)
    else $error("modulo unit restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy))
    else $error("modulo done without a run");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> !busy || $past(req.start))
    else $error("modulo unit still busy after done");

endmodule

[src/tpcd_pins.sv]
// Pin bank: pulse timers, active flags and logical levels, one pin op per cycle.
`timescale 1ns / 1ps

module tpcd_pins #(
  parameter int unsigned PIN_COUNT = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tpcd_pkg::CFG_W-1:0]   pulse_ticks,
  input  tpcd_pkg::pin_op_t            op,
  output logic [PIN_COUNT-1:0]         pin_state
);
  import tpcd_pkg::*;

  localparam int unsigned IDX_W = $clog2(PIN_COUNT);

  logic [CFG_W-1:0]     remaining_ticks [PIN_COUNT];
  logic [PIN_COUNT-1:0] pulse_active;
  logic [IDX_W-1:0]     sel;

  assign sel = op.idx[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_active <= '0;
      pin_state    <= '0;
    end else begin
      unique case (op.code)
        PIN_AGE: begin
          if (pulse_active[sel] && remaining_ticks[sel] == '0) begin
            pin_state[sel]    <= 1'b0;
            pulse_active[sel] <= 1'b0;
          end
        end
        PIN_FIRE: begin
          pin_state[sel]    <= 1'b1;
          pulse_active[sel] <= 1'b1;
        end
        PIN_SET: pin_state[sel] <= op.level;
        PIN_NOP: ;
      endcase
    end
  end

  // shared decrementer on the selected timer
  always_ff @(posedge clk) begin
    if (op.code == PIN_FIRE) begin
      remaining_ticks[sel] <= pulse_ticks;
    end else if (op.code == PIN_AGE && pulse_active[sel] && remaining_ticks[sel] != '0) begin
      remaining_ticks[sel] <= remaining_ticks[sel] - CFG_W'(1);
    end
  end

endmodule
